/* rtl/kea_pkg.sv */
// Package for the union-find edge acceptor: fixed field widths, limits,
// and the command and status bundles between the controller and the datapath.
// No dependencies.
package kea_pkg;

   // Fixed widths of the item fields
   localparam int NODE_PORT_W   = 10;
   localparam int WEIGHT_PORT_W = 16;
   localparam int TOTAL_W       = 26;
   localparam int COUNT_W       = 10;
   localparam int RANK_W        = 4;

   // Saturation limits
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [RANK_W-1:0]  RANK_MAX  = {RANK_W{1'b1}};

   // Controller to datapath commands
   typedef struct packed {
      logic load;         // capture a new item
      logic clr_write;    // write one entry of the clearing pass
      logic clr_totals;   // zero the running weight and edge count
      logic cur_from_u;   // start the walk at the first endpoint
      logic cur_from_v;   // start the walk at the second endpoint
      logic cur_follow;   // step to the parent just read
      logic save_ru;      // hold current node as the first root
      logic save_rv;      // hold current node as the second root
      logic merge_write;  // link the lower-rank root below the other
      logic raise_write;  // bump the rank of the surviving root
      logic accumulate;   // add the weight, count the edge, flag acceptance
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clr_last;      // clearing pass is at the last entry
      logic new_graph;     // held item asks for a fresh graph
      logic in_range;      // both endpoints below the node count
      logic is_root;       // entry just read points at itself
      logic roots_differ;  // the two roots are distinct
      logic ranks_equal;   // the two roots have equal rank
   } status_type;

endpackage

/* rtl/kruskal_edge_acceptor.sv */
// Top level of the union-find edge acceptor: controller plus datapath.
// Depends on kea_pkg, kea_ctrl and kea_dpath.
//
// Edges are handed in with start while busy is low; each edge gives exactly
// one result, shown for one cycle with rsp_valid, and the receiver cannot
// stall it. A new edge is taken only once busy is low again after the last
// result; each edge in range walks the parent links between each endpoint
// and its set root through the registered read of the node memory, and a
// merge of two roots of equal rank adds a rank write. After reset, and on
// every edge that carries new_graph, a clearing pass writes each node back
// as its own root, one node per cycle, while busy stays high. An endpoint at
// or above MAX_NODES gives a rejected edge that adds nothing to the totals.
module kruskal_edge_acceptor #(
   parameter int MAX_NODES   = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [kea_pkg::NODE_PORT_W-1:0]      req_node_u,
   input  logic [kea_pkg::NODE_PORT_W-1:0]      req_node_v,
   input  logic [kea_pkg::WEIGHT_PORT_W-1:0]    req_edge_weight,
   input  logic                                 req_new_graph,
   output logic                                 rsp_valid,
   output logic                                 rsp_accepted,
   output logic [kea_pkg::NODE_PORT_W-1:0]      rsp_edge_u,
   output logic [kea_pkg::NODE_PORT_W-1:0]      rsp_edge_v,
   output logic [kea_pkg::TOTAL_W-1:0]          rsp_tree_weight,
   output logic [kea_pkg::COUNT_W-1:0]          rsp_tree_edges
);

   kea_pkg::cmd_type    cmd;
   kea_pkg::status_type status;

   // Sequencer
   kea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Node memory and totals
   kea_dpath #(
      .MAX_NODES   (MAX_NODES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_node_u      (req_node_u),
      .req_node_v      (req_node_v),
      .req_edge_weight (req_edge_weight),
      .req_new_graph   (req_new_graph),
      .rsp_accepted    (rsp_accepted),
      .rsp_edge_u      (rsp_edge_u),
      .rsp_edge_v      (rsp_edge_v),
      .rsp_tree_weight (rsp_tree_weight),
      .rsp_tree_edges  (rsp_tree_edges)
   );

   // The block is free again right after each result
   a_idle_after_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block still busy after a result");

   // An accepted item makes the block busy at once
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted but block not busy");

   // A merge is only written when the two roots differ
   a_merge_distinct: assert property (@(posedge clock) disable iff (reset)
      cmd.merge_write |-> status.roots_differ)
      else $error("merge written for a single root");

   // An accepted edge always leaves a non-zero edge count
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_tree_edges != '0))
      else $error("accepted edge with zero edge count");

endmodule

/* rtl/kea_ctrl.sv */
// Controller for the union-find edge acceptor: sequences the clearing pass,
// the two root walks, the merge writes and the result strobe.
// Depends on kea_pkg.
module kea_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  kea_pkg::status_type status,
   output kea_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_CLR_BOOT = 4'd1;
   localparam logic [3:0] ST_PREP     = 4'd2;
   localparam logic [3:0] ST_CLR_ITEM = 4'd3;
   localparam logic [3:0] ST_BEGIN    = 4'd4;
   localparam logic [3:0] ST_WAIT_U   = 4'd5;
   localparam logic [3:0] ST_CHECK_U  = 4'd6;
   localparam logic [3:0] ST_WAIT_V   = 4'd7;
   localparam logic [3:0] ST_CHECK_V  = 4'd8;
   localparam logic [3:0] ST_DECIDE   = 4'd9;
   localparam logic [3:0] ST_RAISE    = 4'd10;
   localparam logic [3:0] ST_REPORT   = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_CLR_BOOT: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_PREP: begin
            if (status.new_graph) begin
               cmd.clr_totals = 1'b1;
               state_in       = ST_CLR_ITEM;
            end else begin
               state_in = ST_BEGIN;
            end
         end
         ST_CLR_ITEM: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) begin
               state_in = ST_BEGIN;
            end
         end
         ST_BEGIN: begin
            if (status.in_range) begin
               cmd.cur_from_u = 1'b1;
               state_in       = ST_WAIT_U;
            end else begin
               state_in = ST_REPORT;
            end
         end
         ST_WAIT_U: begin
            state_in = ST_CHECK_U;
         end
         ST_CHECK_U: begin
            if (status.is_root) begin
               cmd.save_ru    = 1'b1;
               cmd.cur_from_v = 1'b1;
               state_in       = ST_WAIT_V;
            end else begin
               cmd.cur_follow = 1'b1;
               state_in       = ST_WAIT_U;
            end
         end
         ST_WAIT_V: begin
            state_in = ST_CHECK_V;
         end
         ST_CHECK_V: begin
            if (status.is_root) begin
               cmd.save_rv = 1'b1;
               state_in    = ST_DECIDE;
            end else begin
               cmd.cur_follow = 1'b1;
               state_in       = ST_WAIT_V;
            end
         end
         ST_DECIDE: begin
            if (status.roots_differ) begin
               cmd.merge_write = 1'b1;
               cmd.accumulate  = 1'b1;
               state_in        = status.ranks_equal ? ST_RAISE : ST_REPORT;
            end else begin
               state_in = ST_REPORT;
            end
         end
         ST_RAISE: begin
            cmd.raise_write = 1'b1;
            state_in        = ST_REPORT;
         end
         ST_REPORT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR_BOOT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_REPORT);

endmodule

/* rtl/kea_dpath.sv */
// Datapath for the union-find edge acceptor: node memory holding rank and
// parent, walk pointer, root registers, running totals and result registers.
// Depends on kea_pkg.
module kea_dpath #(
   parameter int MAX_NODES   = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kea_pkg::cmd_type                     cmd,
   output kea_pkg::status_type                  status,
   input  logic [kea_pkg::NODE_PORT_W-1:0]      req_node_u,
   input  logic [kea_pkg::NODE_PORT_W-1:0]      req_node_v,
   input  logic [kea_pkg::WEIGHT_PORT_W-1:0]    req_edge_weight,
   input  logic                                 req_new_graph,
   output logic                                 rsp_accepted,
   output logic [kea_pkg::NODE_PORT_W-1:0]      rsp_edge_u,
   output logic [kea_pkg::NODE_PORT_W-1:0]      rsp_edge_v,
   output logic [kea_pkg::TOTAL_W-1:0]          rsp_tree_weight,
   output logic [kea_pkg::COUNT_W-1:0]          rsp_tree_edges
);

   localparam int NODE_BITS = $clog2(MAX_NODES);
   localparam int ENTRY_W   = kea_pkg::RANK_W + NODE_BITS;
   localparam logic [31:0] WMASK32 =
      (WEIGHT_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << WEIGHT_BITS) - 32'd1);
   localparam logic [kea_pkg::WEIGHT_PORT_W-1:0] WMASK =
      WMASK32[kea_pkg::WEIGHT_PORT_W-1:0];
   localparam logic [NODE_BITS-1:0] LAST_NODE = NODE_BITS'(MAX_NODES - 1);

   // Node memory: {rank, parent} per node
   logic [ENTRY_W-1:0] node_mem [MAX_NODES];
   logic [ENTRY_W-1:0] rd_ff;
   logic               wr_en;
   logic [NODE_BITS-1:0] wr_addr;
   logic [ENTRY_W-1:0]   wr_data;

   logic [kea_pkg::NODE_PORT_W-1:0]   u_ff, v_ff;
   logic [kea_pkg::WEIGHT_PORT_W-1:0] w_ff;
   logic                              ng_ff;
   logic [NODE_BITS-1:0]              cur_ff, cur_in;
   logic [NODE_BITS-1:0]              ru_ff, rv_ff;
   logic [kea_pkg::RANK_W-1:0]        rku_ff, rkv_ff;
   logic [NODE_BITS-1:0]              clr_ff, clr_in;
   logic [kea_pkg::TOTAL_W-1:0]       total_ff, total_in;
   logic [kea_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic                              acc_ff;

   logic [NODE_BITS-1:0]        rd_parent;
   logic [kea_pkg::RANK_W-1:0]  rd_rank;
   logic [kea_pkg::RANK_W-1:0]  rku_inc;
   logic [kea_pkg::TOTAL_W:0]   sum;
   logic                        clr_last;

   assign rd_parent = rd_ff[NODE_BITS-1:0];
   assign rd_rank   = rd_ff[ENTRY_W-1:NODE_BITS];
   assign clr_last  = (clr_ff == LAST_NODE);
   assign rku_inc   = (rku_ff == kea_pkg::RANK_MAX) ? rku_ff
                                                    : kea_pkg::RANK_W'(rku_ff + 1'b1);

   // Select the single memory write of this cycle
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = {{kea_pkg::RANK_W{1'b0}}, clr_ff};
      if (cmd.clr_write) begin
         wr_en = 1'b1;
      end else if (cmd.merge_write) begin
         wr_en = 1'b1;
         if (rku_ff < rkv_ff) begin
            wr_addr = ru_ff;
            wr_data = {rku_ff, rv_ff};
         end else begin
            wr_addr = rv_ff;
            wr_data = {rkv_ff, ru_ff};
         end
      end else if (cmd.raise_write) begin
         wr_en   = 1'b1;
         wr_addr = ru_ff;
         wr_data = {rku_inc, ru_ff};
      end
   end

   // Memory port: one write, one registered read at the walk pointer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      rd_ff <= node_mem[cur_ff];
   end

   // Walk pointer
   always_comb begin
      cur_in = cur_ff;
      if (cmd.cur_from_u) begin
         cur_in = NODE_BITS'(u_ff);
      end else if (cmd.cur_from_v) begin
         cur_in = NODE_BITS'(v_ff);
      end else if (cmd.cur_follow) begin
         cur_in = rd_parent;
      end
   end

   // Saturating totals
   assign sum = {1'b0, total_ff} + (kea_pkg::TOTAL_W + 1)'(w_ff & WMASK);

   always_comb begin
      total_in = total_ff;
      count_in = count_ff;
      if (cmd.clr_totals) begin
         total_in = '0;
         count_in = '0;
      end else if (cmd.accumulate) begin
         total_in = (sum > {1'b0, kea_pkg::TOTAL_MAX}) ? kea_pkg::TOTAL_MAX
                                                       : sum[kea_pkg::TOTAL_W-1:0];
         count_in = (count_ff == kea_pkg::COUNT_MAX) ? count_ff
                                                     : kea_pkg::COUNT_W'(count_ff + 1'b1);
      end
   end

   // Clearing pass address, wraps to zero after the last node
   always_comb begin
      clr_in = clr_ff;
      if (cmd.clr_write) begin
         clr_in = clr_last ? '0 : NODE_BITS'(clr_ff + 1'b1);
      end
   end

   // Control-side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         total_ff <= '0;
         count_ff <= '0;
         acc_ff   <= 1'b0;
      end else begin
         clr_ff   <= clr_in;
         total_ff <= total_in;
         count_ff <= count_in;
         if (cmd.load) begin
            acc_ff <= 1'b0;
         end else if (cmd.accumulate) begin
            acc_ff <= 1'b1;
         end
      end
   end

   // Item and root payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.load) begin
         u_ff  <= req_node_u;
         v_ff  <= req_node_v;
         w_ff  <= req_edge_weight;
         ng_ff <= req_new_graph;
      end
      if (cmd.save_ru) begin
         ru_ff  <= cur_ff;
         rku_ff <= rd_rank;
      end
      if (cmd.save_rv) begin
         rv_ff  <= cur_ff;
         rkv_ff <= rd_rank;
      end
   end

   // Status back to the controller
   always_comb begin
      status.clr_last     = clr_last;
      status.new_graph    = ng_ff;
      status.in_range     = (32'(u_ff) < 32'(MAX_NODES)) && (32'(v_ff) < 32'(MAX_NODES));
      status.is_root      = (rd_parent == cur_ff);
      status.roots_differ = (ru_ff != rv_ff);
      status.ranks_equal  = (rku_ff == rkv_ff);
   end

   assign rsp_accepted    = acc_ff;
   assign rsp_edge_u      = u_ff;
   assign rsp_edge_v      = v_ff;
   assign rsp_tree_weight = total_ff;
   assign rsp_tree_edges  = count_ff;

endmodule

/* sim/tb.sv */
// Testbench for the union-find edge acceptor: directed corners, one full spanning
// tree and random small graphs, each result checked against an internal predictor.
// Depends on kea_pkg and kruskal_edge_acceptor.
`timescale 1ns / 100ps

module tb;

   localparam int NODE_COUNT   = 1024;
   localparam int WEIGHT_BITS  = 16;
   localparam int QUIET_LIMIT  = 5000;
   localparam int RANDOM_EDGES = 100;

   localparam logic [kea_pkg::WEIGHT_PORT_W-1:0] WEIGHT_MASK =
      (WEIGHT_BITS >= kea_pkg::WEIGHT_PORT_W)
         ? {kea_pkg::WEIGHT_PORT_W{1'b1}}
         : kea_pkg::WEIGHT_PORT_W'((1 << WEIGHT_BITS) - 1);

   typedef struct {
      logic                            accepted;
      logic [kea_pkg::NODE_PORT_W-1:0] edge_u;
      logic [kea_pkg::NODE_PORT_W-1:0] edge_v;
      logic [kea_pkg::TOTAL_W-1:0]     tree_weight;
      logic [kea_pkg::COUNT_W-1:0]     tree_edges;
   } edge_result_type;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [kea_pkg::NODE_PORT_W-1:0]   req_node_u;
   logic [kea_pkg::NODE_PORT_W-1:0]   req_node_v;
   logic [kea_pkg::WEIGHT_PORT_W-1:0] req_edge_weight;
   logic                              req_new_graph;
   logic                              rsp_valid;
   logic                              rsp_accepted;
   logic [kea_pkg::NODE_PORT_W-1:0]   rsp_edge_u;
   logic [kea_pkg::NODE_PORT_W-1:0]   rsp_edge_v;
   logic [kea_pkg::TOTAL_W-1:0]       rsp_tree_weight;
   logic [kea_pkg::COUNT_W-1:0]       rsp_tree_edges;

   // Predictor state: forest, ranks and running totals
   int unsigned                   parent_of [NODE_COUNT];
   logic [kea_pkg::RANK_W-1:0]    rank_of [NODE_COUNT];
   logic [kea_pkg::TOTAL_W-1:0]   tree_total;
   logic [kea_pkg::COUNT_W-1:0]   tree_count;

   edge_result_type pending_results[$];
   int              error_count = 0;
   int              quiet_cycles = 0;
   int              idle_pct = 17;

   kruskal_edge_acceptor #(
      .MAX_NODES   (NODE_COUNT),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_node_u      (req_node_u),
      .req_node_v      (req_node_v),
      .req_edge_weight (req_edge_weight),
      .req_new_graph   (req_new_graph),
      .rsp_valid       (rsp_valid),
      .rsp_accepted    (rsp_accepted),
      .rsp_edge_u      (rsp_edge_u),
      .rsp_edge_v      (rsp_edge_v),
      .rsp_tree_weight (rsp_tree_weight),
      .rsp_tree_edges  (rsp_tree_edges)
   );

   // Free-running clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Put every node back into its own set and zero the totals
   function automatic void clear_forest();
      for (int i = 0; i < NODE_COUNT; i++) begin
         parent_of[i] = i;
         rank_of[i]   = '0;
      end
      tree_total = '0;
      tree_count = '0;
   endfunction

   // Walk parent links up to the set root, bounded by the node count
   function automatic int unsigned find_set_root(int unsigned node);
      int unsigned here;
      int unsigned up;
      here = node;
      for (int steps = 0; steps < NODE_COUNT; steps++) begin
         up = parent_of[here];
         if (up >= NODE_COUNT || up == here) break;
         here = up;
      end
      return here;
   endfunction

   // Handle one edge: merge by rank when the roots differ, update the totals
   function automatic edge_result_type join_edge(logic [kea_pkg::NODE_PORT_W-1:0] u,
                                                 logic [kea_pkg::NODE_PORT_W-1:0] v,
                                                 logic [kea_pkg::WEIGHT_PORT_W-1:0] w,
                                                 logic fresh);
      edge_result_type r;
      int unsigned     ru;
      int unsigned     rv;
      logic [kea_pkg::TOTAL_W:0] sum;
      if (fresh) clear_forest();
      r.accepted = 1'b0;
      if (u < NODE_COUNT && v < NODE_COUNT) begin
         ru = find_set_root(32'(u));
         rv = find_set_root(32'(v));
         if (ru != rv) begin
            r.accepted = 1'b1;
            if (rank_of[ru] < rank_of[rv]) begin
               parent_of[ru] = rv;
            end else if (rank_of[ru] > rank_of[rv]) begin
               parent_of[rv] = ru;
            end else begin
               parent_of[rv] = ru;
               if (rank_of[ru] != kea_pkg::RANK_MAX) rank_of[ru] = rank_of[ru] + 1'b1;
            end
            sum = {1'b0, tree_total} + (kea_pkg::TOTAL_W + 1)'(w & WEIGHT_MASK);
            tree_total = (sum > {1'b0, kea_pkg::TOTAL_MAX}) ? kea_pkg::TOTAL_MAX
                                                            : sum[kea_pkg::TOTAL_W-1:0];
            if (tree_count != kea_pkg::COUNT_MAX) tree_count = tree_count + 1'b1;
         end
      end
      r.edge_u      = u;
      r.edge_v      = v;
      r.tree_weight = tree_total;
      r.tree_edges  = tree_count;
      return r;
   endfunction

   // Offer one item after a random idle gap; record its expected result on acceptance
   task automatic send_edge(input logic [kea_pkg::NODE_PORT_W-1:0] u,
                            input logic [kea_pkg::NODE_PORT_W-1:0] v,
                            input logic [kea_pkg::WEIGHT_PORT_W-1:0] w,
                            input logic fresh);
      edge_result_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start           = 1'b1;
      req_node_u      = u;
      req_node_v      = v;
      req_edge_weight = w;
      req_new_graph   = fresh;
      do @(posedge clock); while (busy !== 1'b0);
      predicted       = join_edge(u, v, w, fresh);
      pending_results = {pending_results, predicted};
   endtask

   // Drop start once a test has handed over its last item
   task automatic release_start();
      @(negedge clock);
      start = 1'b0;
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Compare each result with the oldest outstanding expectation
   always @(posedge clock) begin : check_results
      edge_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result for edge %0d-%0d with no item outstanding",
                     $time, rsp_edge_u, rsp_edge_v);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
            check_field("edge_u", 32'(want.edge_u), 32'(rsp_edge_u));
            check_field("edge_v", 32'(want.edge_v), 32'(rsp_edge_v));
            check_field("tree_weight", 32'(want.tree_weight), 32'(rsp_tree_weight));
            check_field("tree_edges", 32'(want.tree_edges), 32'(rsp_tree_edges));
         end
      end
   end

   // Abort when nothing moves on either side for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Extremes of every field, self loops, repeated joins and a fresh graph mid-stream
   task automatic test_corner_edges();
      idle_pct = 17;
      send_edge(10'd0, 10'd1023, 16'hFFFF, 1'b1);
      send_edge(10'd1023, 10'd0, 16'hFFFF, 1'b0);
      send_edge(10'd5, 10'd5, 16'd1234, 1'b0);
      send_edge(10'd0, 10'd0, 16'h0000, 1'b0);
      send_edge(10'd1023, 10'd1023, 16'hFFFF, 1'b0);
      send_edge(10'h2AA, 10'h155, 16'hAAAA, 1'b0);
      send_edge(10'h155, 10'h2AA, 16'h5555, 1'b0);
      send_edge(10'h2AA, 10'd1023, 16'h0000, 1'b0);
      send_edge(10'h155, 10'd0, 16'd1, 1'b0);
      send_edge(10'd1, 10'd2, 16'd7, 1'b0);
      send_edge(10'd3, 10'd4, 16'd9, 1'b0);
      send_edge(10'd2, 10'd3, 16'd11, 1'b0);
      send_edge(10'd1, 10'd4, 16'd13, 1'b0);
      send_edge(10'd4, 10'd0, 16'hFFFF, 1'b0);
      send_edge(10'd8, 10'd9, 16'd100, 1'b1);
      send_edge(10'd0, 10'd1023, 16'd5, 1'b0);
      send_edge(10'd1023, 10'd0, 16'd5, 1'b0);
      send_edge(10'd9, 10'd8, 16'd5, 1'b0);
      release_start();
   endtask

   // Join every node into one tree at maximum weight, then offer redundant edges
   task automatic test_full_tree();
      int order [NODE_COUNT];
      int j;
      int tmp;
      idle_pct = 0;
      for (int i = 0; i < NODE_COUNT; i++) order[i] = i;
      for (int i = NODE_COUNT - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      send_edge(kea_pkg::NODE_PORT_W'(order[1]), kea_pkg::NODE_PORT_W'(order[0]),
                16'hFFFF, 1'b1);
      for (int i = 2; i < NODE_COUNT; i++) begin
         if ($urandom_range(0, 1) == 0)
            send_edge(kea_pkg::NODE_PORT_W'(order[i]),
                      kea_pkg::NODE_PORT_W'(order[$urandom_range(0, i - 1)]),
                      16'hFFFF, 1'b0);
         else
            send_edge(kea_pkg::NODE_PORT_W'(order[$urandom_range(0, i - 1)]),
                      kea_pkg::NODE_PORT_W'(order[i]),
                      16'hFFFF, 1'b0);
      end
      for (int i = 0; i < 8; i++)
         send_edge(kea_pkg::NODE_PORT_W'($urandom_range(0, NODE_COUNT - 1)),
                   kea_pkg::NODE_PORT_W'($urandom_range(0, NODE_COUNT - 1)),
                   16'hFFFF, 1'b0);
      release_start();
   endtask

   // Random graphs over node windows of varying width, with some stray edges
   task automatic test_random_graphs();
      int edges_sent;
      int span;
      int base;
      int graph_edges;
      logic [kea_pkg::NODE_PORT_W-1:0]   u;
      logic [kea_pkg::NODE_PORT_W-1:0]   v;
      logic [kea_pkg::WEIGHT_PORT_W-1:0] w;
      logic fresh;
      edges_sent = 0;
      while (edges_sent < RANDOM_EDGES) begin
         span        = ($urandom_range(0, 3) == 0) ? $urandom_range(64, NODE_COUNT - 1)
                                                   : $urandom_range(1, 40);
         base        = $urandom_range(0, NODE_COUNT - 1 - span);
         graph_edges = $urandom_range(5, 60);
         idle_pct    = ($urandom_range(0, 5) == 0) ? 0 : 17;
         for (int k = 0; k < graph_edges; k++) begin
            fresh = (k == 0) || ($urandom_range(0, 99) == 0);
            if ($urandom_range(0, 9) == 0) begin
               u = kea_pkg::NODE_PORT_W'($urandom_range(0, NODE_COUNT - 1));
               v = kea_pkg::NODE_PORT_W'($urandom_range(0, NODE_COUNT - 1));
            end else begin
               u = kea_pkg::NODE_PORT_W'(base + $urandom_range(0, span));
               v = kea_pkg::NODE_PORT_W'(base + $urandom_range(0, span));
            end
            case ($urandom_range(0, 9))
               0:       w = '0;
               1:       w = '1;
               default: w = kea_pkg::WEIGHT_PORT_W'($urandom_range(0, 16'hFFFF));
            endcase
            send_edge(u, v, w, fresh);
            edges_sent++;
         end
      end
      release_start();
   endtask

   // Reset once, run the tests in turn, then drain and report
   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_node_u      = '0;
      req_node_v      = '0;
      req_edge_weight = '0;
      req_new_graph   = 1'b0;
      clear_forest();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_corner_edges();
      test_full_tree();
      test_random_graphs();

      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
